@@ src/rsp_pkg.sv @@
// Shared types, constants and step functions for the RMSprop update unit.
package rsp_pkg;

  localparam int PARAM_COUNT = 1024;
  localparam int IDX_W       = $clog2(PARAM_COUNT);
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = 34;

  localparam logic [16:0] BETA_ONE = 17'd65536;

  localparam logic [1:0] REG_LEARNING_RATE    = 2'd0;
  localparam logic [1:0] REG_DECAY_WEIGHT     = 2'd1;
  localparam logic [1:0] REG_DENOMINATOR_BIAS = 2'd2;

  localparam logic [31:0] LR_RESET   = 32'd16777;
  localparam logic [16:0] BETA_RESET = 17'd58982;
  localparam logic [31:0] BIAS_RESET = 32'd1;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             gneg;
    logic             gzero;
    logic [31:0]      p;
    logic [63:0]      num;
  } sq_side_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             gneg;
    logic             gzero;
    logic             big;
    logic [31:0]      p;
  } dv_side_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
  } sq_state_t;

  typedef struct packed {
    logic [31:0] rem;
    logic        qbit;
  } dv_state_t;

  // One digit of the integer square root: bring down two bits, try root*4+1.
  function automatic sq_state_t sqrt_step(logic [33:0] rem, logic [31:0] root,
                                          logic [1:0] bits);
    logic [35:0] cur;
    logic [35:0] trial;
    sq_state_t   r;
    cur   = {rem, bits};
    trial = {2'b00, root, 2'b01};
    if (cur >= trial) begin
      r.rem  = 34'(cur - trial);
      r.root = {root[30:0], 1'b1};
    end else begin
      r.rem  = cur[33:0];
      r.root = {root[30:0], 1'b0};
    end
    return r;
  endfunction

  // One quotient bit of restoring division; rem stays below the divisor.
  function automatic dv_state_t div_step(logic [31:0] rem, logic [31:0] dvs, logic nbit);
    logic [32:0] cur;
    dv_state_t   r;
    cur = {rem, nbit};
    if (cur >= {1'b0, dvs}) begin
      r.rem  = 32'(cur - {1'b0, dvs});
      r.qbit = 1'b1;
    end else begin
      r.rem  = cur[31:0];
      r.qbit = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ src/rsp_in_if.sv @@
// Input channel: one gradient request per handshake.
interface rsp_in_if;
  logic               valid;
  logic               ready;
  logic [9:0]         param_index;
  logic signed [31:0] gradient;
  logic signed [31:0] current_param;
  modport source (output valid, param_index, gradient, current_param, input ready);
  modport sink (input valid, param_index, gradient, current_param, output ready);
endinterface

@@ src/rsp_out_if.sv @@
// Output channel: one updated parameter per handshake.
interface rsp_out_if;
  logic               valid;
  logic               ready;
  logic [9:0]         out_index;
  logic signed [31:0] updated_param;
  modport source (output valid, out_index, updated_param, input ready);
  modport sink (input valid, out_index, updated_param, output ready);
endinterface

@@ src/rsp_sqrt.sv @@
// Pipelined 64-bit integer square root, one root bit per stage.
module rsp_sqrt
  import rsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] rad,
  input  sq_side_t    in_side,
  output logic        out_valid,
  output logic [31:0] root,
  output sq_side_t    out_side
);

  logic [SQRT_STEPS-1:0] vld;
  logic [33:0]           rem_q  [SQRT_STEPS];
  logic [31:0]           root_q [SQRT_STEPS];
  logic [63:0]           rad_q  [SQRT_STEPS];
  sq_side_t              side_q [SQRT_STEPS];
  sq_state_t             nxt    [SQRT_STEPS];

  always_comb begin
    nxt[0] = sqrt_step(34'd0, 32'd0, rad[63:62]);
    for (int k = 1; k < SQRT_STEPS; k++) begin
      nxt[k] = sqrt_step(rem_q[k-1], root_q[k-1], rad_q[k-1][63:62]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[SQRT_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= nxt[0].rem;
      root_q[0] <= nxt[0].root;
      rad_q[0]  <= {rad[61:0], 2'b00};
      side_q[0] <= in_side;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        rem_q[k]  <= nxt[k].rem;
        root_q[k] <= nxt[k].root;
        rad_q[k]  <= {rad_q[k-1][61:0], 2'b00};
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign out_valid = vld[SQRT_STEPS-1];
  assign root      = root_q[SQRT_STEPS-1];
  assign out_side  = side_q[SQRT_STEPS-1];

endmodule

@@ src/rsp_div.sv @@
// Pipelined restoring divider: 34-bit quotient of a 56-bit dividend.
module rsp_div
  import rsp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [55:0]          dividend,
  input  logic [31:0]          divisor,
  input  dv_side_t             in_side,
  output logic                 out_valid,
  output logic [DIV_STEPS-1:0] quot,
  output dv_side_t             out_side
);

  logic [DIV_STEPS-1:0] vld;
  logic [31:0]          rem_q  [DIV_STEPS];
  logic [DIV_STEPS-1:0] q_q    [DIV_STEPS];
  logic [DIV_STEPS-1:0] low_q  [DIV_STEPS];
  logic [31:0]          dvs_q  [DIV_STEPS];
  dv_side_t             side_q [DIV_STEPS];
  dv_state_t            nxt    [DIV_STEPS];

  // The caller guarantees the top bits of the dividend stay below the divisor.
  always_comb begin
    nxt[0] = div_step(32'(dividend[55:DIV_STEPS]), divisor, dividend[DIV_STEPS-1]);
    for (int k = 1; k < DIV_STEPS; k++) begin
      nxt[k] = div_step(rem_q[k-1], dvs_q[k-1], low_q[k-1][DIV_STEPS-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= nxt[0].rem;
      q_q[0]    <= {{(DIV_STEPS-1){1'b0}}, nxt[0].qbit};
      low_q[0]  <= {dividend[DIV_STEPS-2:0], 1'b0};
      dvs_q[0]  <= divisor;
      side_q[0] <= in_side;
      for (int k = 1; k < DIV_STEPS; k++) begin
        rem_q[k]  <= nxt[k].rem;
        q_q[k]    <= {q_q[k-1][DIV_STEPS-2:0], nxt[k].qbit};
        low_q[k]  <= {low_q[k-1][DIV_STEPS-2:0], 1'b0};
        dvs_q[k]  <= dvs_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign out_valid = vld[DIV_STEPS-1];
  assign quot      = q_q[DIV_STEPS-1];
  assign out_side  = side_q[DIV_STEPS-1];

endmodule

@@ src/rmsprop_param_update_unit.sv @@
// RMSprop update unit: mean-square store, blend, root and divide pipeline.
// Throughput: one request per cycle while the result is not stalled; the
// mean-square read-modify-write closes in one blend stage, with the previous
// result forwarded for a repeated index. A stalled result holds the whole
// pipeline. After reset the store is cleared one entry per cycle, during which
// no request is accepted.
module rmsprop_param_update_unit
  import rsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  rsp_in_if.sink      grad,
  rsp_out_if.source   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic [31:0] step_rate;
  logic [16:0] decay_weight;
  logic [31:0] denominator_bias;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_rate        <= LR_RESET;
      decay_weight     <= BETA_RESET;
      denominator_bias <= BIAS_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_LEARNING_RATE:    step_rate        <= pwdata;
        REG_DECAY_WEIGHT:     decay_weight     <= pwdata[16:0];
        REG_DENOMINATOR_BIAS: denominator_bias <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LEARNING_RATE:    prdata = step_rate;
      REG_DECAY_WEIGHT:     prdata = {15'd0, decay_weight};
      REG_DENOMINATOR_BIAS: prdata = denominator_bias;
      default:              prdata = 32'd0;
    endcase
  end

  logic [16:0] beta;
  logic [16:0] beta_c;
  assign beta   = (decay_weight > BETA_ONE) ? BETA_ONE : decay_weight;
  assign beta_c = BETA_ONE - beta;

  // Store clear after reset
  logic [IDX_W:0] clr_cnt;
  logic           clearing;
  assign clearing = !clr_cnt[IDX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Global advance: everything moves unless the result register is stuck
  logic adv;
  logic out_v;
  assign adv        = !out_v || result.ready;
  assign grad.ready = adv && !clearing;

  logic accept;
  assign accept = grad.valid && grad.ready;

  // Stage 1: magnitude and sign of the gradient
  logic             v1, v2, v3, v4, v5;
  logic [IDX_W-1:0] idx1, idx2, idx3, idx4;
  logic             gneg1, gneg2, gneg3, gneg4;
  logic [31:0]      gmag1, gmag2;
  logic [31:0]      p1, p2, p3, p4;
  logic [63:0]      g2_2;
  logic [80:0]      x3;
  logic [63:0]      num3, num4;
  logic [63:0]      mean4;
  logic [63:0]      rd_data;
  logic [63:0]      mean_prev;
  logic             fwd;
  logic [63:0]      rad5;
  sq_side_t         side5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Blend stage: m' = (beta*m + (1-beta)*g*g) >> 16, saturated
  logic [63:0] old_mean;
  logic [80:0] bm;
  logic [81:0] blend_sum;
  logic [63:0] mean3;

  always_comb begin
    old_mean  = fwd ? mean_prev : rd_data;
    bm        = 81'(old_mean) * 81'(beta);
    blend_sum = {1'b0, bm} + {1'b0, x3};
    mean3     = (blend_sum[81:80] != 2'b00) ? {64{1'b1}} : blend_sum[79:16];
  end

  // Denominator: mean plus bias, saturated
  logic [64:0] dsum;
  assign dsum = {1'b0, mean4} + {17'd0, denominator_bias, 16'd0};

  // Flag a zero gradient separately, since a zero step rate also zeroes num
  logic gzero3, gzero4;
  always_ff @(posedge clk) begin
    if (adv) begin
      gzero3 <= (gmag2 == 32'd0);
      gzero4 <= gzero3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx1  <= grad.param_index;
      gneg1 <= grad.gradient[31];
      gmag1 <= grad.gradient[31] ? 32'(-grad.gradient) : grad.gradient;
      p1    <= grad.current_param;

      idx2  <= idx1;
      gneg2 <= gneg1;
      gmag2 <= gmag1;
      p2    <= p1;
      g2_2  <= 64'(gmag1) * 64'(gmag1);

      idx3  <= idx2;
      gneg3 <= gneg2;
      p3    <= p2;
      x3    <= 81'(g2_2) * 81'(beta_c);
      num3  <= 64'(step_rate) * 64'(gmag2);
      fwd   <= v2 && v3 && (idx2 == idx3);

      idx4      <= idx3;
      gneg4     <= gneg3;
      p4        <= p3;
      num4      <= num3;
      mean4     <= mean3;
      mean_prev <= mean3;

      rad5        <= dsum[64] ? {64{1'b1}} : dsum[63:0];
      side5.idx   <= idx4;
      side5.gneg  <= gneg4;
      side5.gzero <= gzero4;
      side5.p     <= p4;
      side5.num   <= num4;
    end
  end

  // Mean-square store: one write port, one registered read port
  logic [63:0] mem [PARAM_COUNT];

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt[IDX_W-1:0]] <= 64'd0;
    end else if (adv && v3) begin
      mem[idx3] <= mean3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data <= mem[idx2];
    end
  end

  // Square root
  logic        sq_v;
  logic [31:0] sq_root;
  sq_side_t    sq_side;

  rsp_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v5),
    .rad       (rad5),
    .in_side   (side5),
    .out_valid (sq_v),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  // Divide setup: corr = (num >> 8) / root, large quotients go straight to the rail
  logic [55:0] nsh;
  logic        big;
  assign nsh = sq_side.num[63:8];
  assign big = !sq_side.gzero &&
               ((sq_root == 32'd0) || ({10'd0, nsh[55:DIV_STEPS]} >= sq_root));

  logic        v6;
  logic [55:0] dvd6;
  logic [31:0] dvs6;
  dv_side_t    side6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dvd6        <= (big || sq_side.gzero) ? 56'd0 : nsh;
      dvs6        <= (big || sq_side.gzero) ? 32'd1 : sq_root;
      side6.idx   <= sq_side.idx;
      side6.gneg  <= sq_side.gneg;
      side6.gzero <= sq_side.gzero;
      side6.big   <= big;
      side6.p     <= sq_side.p;
    end
  end

  logic                 dv_v;
  logic [DIV_STEPS-1:0] dv_q;
  dv_side_t             dv_side;

  rsp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v6),
    .dividend  (dvd6),
    .divisor   (dvs6),
    .in_side   (side6),
    .out_valid (dv_v),
    .quot      (dv_q),
    .out_side  (dv_side)
  );

  // Apply the correction and saturate
  logic [DIV_STEPS-1:0] corr;
  logic [35:0]          pext;
  logic [35:0]          res;
  logic [31:0]          res_sat;

  always_comb begin
    corr = dv_side.gzero ? '0 : dv_q;
    pext = {{4{dv_side.p[31]}}, dv_side.p};
    res  = dv_side.gneg ? pext + {2'b00, corr} : pext - {2'b00, corr};
    if (dv_side.big) begin
      res_sat = dv_side.gneg ? 32'h7FFF_FFFF : 32'h8000_0000;
    end else if (!res[35] && (res[34:31] != 4'd0)) begin
      res_sat = 32'h7FFF_FFFF;
    end else if (res[35] && (res[34:31] != 4'hF)) begin
      res_sat = 32'h8000_0000;
    end else begin
      res_sat = res[31:0];
    end
  end

  logic [IDX_W-1:0] out_idx;
  logic [31:0]      out_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_idx <= dv_side.idx;
      out_val <= res_sat;
    end
  end

  assign result.valid         = out_v;
  assign result.out_index     = out_idx;
  assign result.updated_param = out_val;

endmodule

@@ bench/rmsprop_update_checker.sv @@
// Checker: watches the channels and config port, predicts each parameter update and compares.
module rmsprop_update_checker
  import rsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  rsp_in_if           grad,
  rsp_out_if          result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);

  typedef struct {
    logic [9:0]  idx;
    logic [31:0] val;
  } update_t;

  update_t     update_q[$];
  logic [31:0] step_size;
  logic [16:0] decay;
  logic [31:0] bias;
  logic [63:0] msq_mirror [PARAM_COUNT];

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bitv;
    r    = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // Advance the mean-square mirror for idx and return the new parameter value.
  function automatic logic [31:0] update_param(logic [9:0] idx, logic [31:0] g,
                                               logic [31:0] p);
    logic        gneg;
    logic [31:0] gmag;
    logic [16:0] b;
    logic [63:0] old;
    logic [127:0] blend;
    logic [63:0] mean;
    logic [64:0] dsum;
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] num;
    logic [63:0] corr;
    longint      res;
    gneg  = g[31];
    gmag  = gneg ? -g : g;
    b     = (decay > BETA_ONE) ? BETA_ONE : decay;
    old   = (idx < PARAM_COUNT) ? msq_mirror[idx] : 64'd0;
    blend = 128'(old) * 128'(b)
          + 128'(64'(gmag) * 64'(gmag)) * 128'(BETA_ONE - b);
    mean  = blend[79:16];
    if (blend[127:80] != 0) mean = '1;
    if (idx < PARAM_COUNT) msq_mirror[idx] = mean;
    dsum  = 65'(mean) + (65'(bias) << 16);
    d     = dsum[64] ? '1 : dsum[63:0];
    s     = int_sqrt(d);
    num   = 64'(step_size) * 64'(gmag);
    if (gmag == 0) corr = 0;
    else if (s == 0) corr = 64'd1 << 40;
    else corr = num / (s << 8);
    res = gneg ? longint'($signed(p)) + longint'(corr) : longint'($signed(p)) - longint'(corr);
    if (res > 64'sh7FFF_FFFF) res = 64'sh7FFF_FFFF;
    if (res < -64'sh8000_0000) res = -64'sh8000_0000;
    return res[31:0];
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    update_t u;
    if (rst) begin
      step_size = LR_RESET;
      decay     = BETA_RESET;
      bias      = BIAS_RESET;
      foreach (msq_mirror[i]) msq_mirror[i] = '0;
      update_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_LEARNING_RATE:    step_size = pwdata;
          REG_DECAY_WEIGHT:     decay     = pwdata[16:0];
          REG_DENOMINATOR_BIAS: bias      = pwdata;
          default: ;  // drop writes to unmapped addresses
        endcase
      end
      if (result.valid && result.ready) begin
        if (update_q.size() == 0) begin
          report("unexpected result", {22'd0, result.out_index}, 32'd0);
        end else begin
          u = update_q.pop_front();
          if (result.out_index !== u.idx) report("out_index", {22'd0, result.out_index},
                                                 {22'd0, u.idx});
          if (result.updated_param !== u.val) report("updated_param", result.updated_param,
                                                     u.val);
        end
      end
      if (grad.valid && grad.ready) begin
        u.idx = grad.param_index;
        u.val = update_param(grad.param_index, grad.gradient, grad.current_param);
        update_q.push_back(u);
      end
    end
    pending = update_q.size();
  end

endmodule

@@ bench/rmsprop_param_update_unit_tb.sv @@
// Testbench top: clock, reset, stimulus, config writes and the final verdict.
module rmsprop_param_update_unit_tb
  import rsp_pkg::*;
();

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN      = 100;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          idle_cycles;
  int          stall_mode;

  rsp_in_if  grad ();
  rsp_out_if result ();

  rmsprop_param_update_unit uut (
    .clk, .rst, .grad(grad.sink), .result(result.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  rmsprop_update_checker checker_i (
    .clk, .rst, .grad, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(512)) - 256);
      3: return 32'($signed($urandom_range(1 << 18)) - (1 << 17));
      4: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Output back-pressure: long runs with no stall, mixed with random stalls.
  always @(negedge clk) begin
    if ($urandom_range(199) == 0) stall_mode = $urandom_range(2);
    case (stall_mode)
      0: result.ready <= 1'b1;
      1: result.ready <= ($urandom_range(3) != 0);
      default: result.ready <= ($urandom_range(19) != 0) ? 1'b1 : ($urandom_range(4) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (grad.valid && grad.ready) || (result.valid && result.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Called at a falling edge; leaves valid high so back-to-back requests need no drop.
  task automatic send_request(logic [9:0] idx, logic [31:0] g, logic [31:0] p);
    int n;
    n = gap_len();
    if (n > 0) begin
      grad.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    grad.valid         <= 1'b1;
    grad.param_index   <= idx;
    grad.gradient      <= g;
    grad.current_param <= p;
    @(posedge clk);
    while (!grad.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic reg_write(logic [1:0] regno, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {regno, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    grad.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] lr, logic [31:0] beta, logic [31:0] bias);
    wait_drained();
    reg_write(REG_LEARNING_RATE, lr);
    reg_write(REG_DECAY_WEIGHT, beta);
    reg_write(REG_DENOMINATOR_BIAS, bias);
  endtask

  task automatic random_burst(int count);
    logic [9:0] hot;
    hot = 10'($urandom);
    for (int i = 0; i < count; i++) begin
      // Favor a few hot indexes so back-to-back repeats hit the forwarding path.
      case ($urandom_range(3))
        0: send_request(hot, pick_value(), pick_value());
        1: send_request(hot + 10'($urandom_range(3)), pick_value(), pick_value());
        default: send_request(10'($urandom), pick_value(), pick_value());
      endcase
      if ($urandom_range(15) == 0) hot = 10'($urandom);
    end
  endtask

  initial begin
    rst                = 1'b1;
    stall_mode         = 0;
    idle_cycles        = 0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    grad.valid         = 1'b0;
    grad.param_index   = '0;
    grad.gradient      = '0;
    grad.current_param = '0;
    result.ready       = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Defaults: field extremes and repeated indexes.
    send_request(10'd0, 32'h0000_0000, 32'h0001_0000);
    send_request(10'd0, 32'h0001_0000, 32'h0001_0000);
    send_request(10'd0, 32'hFFFF_0000, 32'h0000_0000);
    send_request(10'd1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(10'd1023, 32'h8000_0000, 32'h8000_0000);
    send_request(10'd512, 32'h0000_0001, 32'h7FFF_FFFF);
    send_request(10'd512, 32'hFFFF_FFFF, 32'h8000_0000);
    send_request(10'd341, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(10'd682, 32'hAAAA_AAAA, 32'h5555_5555);

    // Beta of one with no bias: zero root drives the result to a rail.
    set_config(32'hFFFF_FFFF, 32'd65536, 32'd0);
    send_request(10'd7, 32'h0000_0001, 32'h0000_0000);
    send_request(10'd8, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(10'd9, 32'h0000_0000, 32'h1234_5678);
    send_request(10'd0, 32'h0010_0000, 32'hFFFF_0000);

    // Beta above one acts as one; zero step; unmapped register ignored.
    set_config(32'd0, 32'h0001_FFFF, 32'hFFFF_FFFF);
    reg_write(2'd3, 32'hFFFF_FFFF);
    send_request(10'd1023, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(10'd1, 32'h8000_0000, 32'h7FFF_FFFF);

    // Beta zero: mean follows g*g alone.
    set_config(32'd1, 32'd0, 32'd0);
    send_request(10'd2, 32'h8000_0000, 32'h0000_0000);
    send_request(10'd3, 32'h0000_0100, 32'h0000_0000);
    send_request(10'd2, 32'h7FFF_FFFF, 32'h8000_0000);

    random_burst(200);
    set_config(LR_RESET, BETA_RESET, BIAS_RESET);
    random_burst(250);
    set_config(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    random_burst(150);
    for (int ph = 0; ph < 6; ph++) begin
      set_config($urandom_range(1) ? $urandom : 32'($urandom_range(1 << 20, 1)),
                 $urandom_range(65536), $urandom_range(1) ? $urandom : $urandom_range(255));
      random_burst(150);
    end

    wait_drained();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
